[hdl/dioc_pkg.sv]
// shared types, character codes and helpers for the door i/o command controller
// no dependencies; imported by dioc_core, dioc_emit and the top level
`timescale 1ns / 1ps

package dioc_pkg;

  // parser states
  localparam logic [1:0] PS_CMD  = 2'd0;
  localparam logic [1:0] PS_PARM = 2'd1;
  localparam logic [1:0] PS_TERM = 2'd2;

  // ascii codes
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_FIRST = 8'h21;  // first printable, non-space byte
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_LO_G  = 8'h67;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_UP_L  = 8'h4c;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_I     = 8'h69;

  localparam logic [7:0] TMR_LATCHED = 8'hff;
  localparam logic [3:0] DIGIT_MASK  = 4'hf;
  localparam logic [4:0] INV_MASK    = 5'h1f;
  localparam logic [2:0] REPORT_TAG  = 3'b001;  // report byte is inputs | 0x20

  localparam int NPINS = 5;

  // what a pass sends
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // a plain report starts at byte position RPT_BASE of the status answer; the LEN_ values are answer lengths
  localparam logic [3:0] RPT_BASE   = 4'd5;
  localparam logic [3:0] LEN_NONE   = 4'd1;
  localparam logic [3:0] LEN_REPORT = 4'd4;
  localparam logic [3:0] LEN_STATUS = 4'd9;

  typedef struct packed {
    logic [1:0]       kind;
    logic             st_beep;   // timer flags for the status line
    logic             st_green;
    logic             st_strike;
    logic [NPINS-1:0] rpt;       // debounced inputs for the report
    logic             strike_on;
    logic             green_on;
    logic             beep_on;
  } pass_desc_t;

  function automatic logic [7:0] resp_byte(input logic [3:0] pos, input pass_desc_t d);
    logic [7:0] r8;
    logic [7:0] b;
    r8 = {REPORT_TAG, d.rpt};
    case (pos)
      4'd0:    b = CH_QUERY;
      4'd1:    b = CH_ZERO | {7'd0, d.st_beep};
      4'd2:    b = CH_ZERO | {7'd0, d.st_green};
      4'd3:    b = CH_ZERO | {7'd0, d.st_strike};
      4'd4:    b = CH_LF;
      4'd5:    b = CH_I;
      4'd6:    b = r8;
      4'd7:    b = r8 ^ {3'd0, INV_MASK};
      4'd8:    b = CH_LF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[hdl/dioc_core.sv]
// controller state: command parser, timers, input debouncer and report flag
// depends on dioc_pkg; builds the pass descriptor for dioc_emit
`timescale 1ns / 1ps

module dioc_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    rx_valid,
  input  logic [7:0]              rx_byte,
  input  logic                    tick,
  input  logic [dioc_pkg::NPINS-1:0] pins,
  output dioc_pkg::pass_desc_t    desc
);
  import dioc_pkg::*;

  logic [1:0]       pstate_r, pstate_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       parm_r, parm_nxt;
  logic [7:0]       beep_r, beep_nxt;
  logic [7:0]       green_r, green_nxt;
  logic [7:0]       strike_r, strike_nxt;
  logic [NPINS-1:0] stable_r, stable_nxt;
  logic             pend_r, pend_nxt;
  logic [NPINS-1:0] cnt_a_r, cnt_a_nxt;
  logic [NPINS-1:0] cnt_b_r, cnt_b_nxt;
  logic [NPINS-1:0] cnt_c_r, cnt_c_nxt;

  always_comb begin
    logic             run;
    logic             is_status;
    logic             parm_ok;
    logic [7:0]       new_val;
    logic [7:0]       bt, gt, stt;
    logic [NPINS-1:0] a, b, c, diff, done;

    pstate_nxt = pstate_r;
    cmd_nxt    = cmd_r;
    parm_nxt   = parm_r;
    run        = 1'b0;

    // parser
    if (rx_valid) begin
      if (pstate_r == PS_TERM) begin
        run        = (rx_byte == CH_LF) || (rx_byte == CH_CR);
        pstate_nxt = PS_CMD;
      end else if (rx_byte < CH_FIRST) begin
        pstate_nxt = PS_CMD;
      end else if (pstate_r == PS_PARM) begin
        parm_nxt   = rx_byte;
        pstate_nxt = PS_TERM;
      end else begin
        cmd_nxt    = rx_byte;
        pstate_nxt = PS_PARM;
      end
    end

    // command execution
    parm_ok = 1'b1;
    new_val = {parm_r[3:0] & DIGIT_MASK, 4'd0};
    if (parm_r == CH_UP_L || parm_r == CH_LO_L) begin
      new_val = TMR_LATCHED;
    end else if (!(parm_r inside {[CH_ZERO:CH_NINE]})) begin
      parm_ok = 1'b0;
    end
    bt  = beep_r;
    gt  = green_r;
    stt = strike_r;
    is_status = 1'b0;
    if (run) begin
      if ((cmd_r == CH_UP_B || cmd_r == CH_LO_B) && parm_ok) begin
        bt = new_val;
      end else if ((cmd_r == CH_UP_G || cmd_r == CH_LO_G) && parm_ok) begin
        gt = new_val;
      end else if ((cmd_r == CH_UP_S || cmd_r == CH_LO_S) && parm_ok) begin
        stt = new_val;
      end else if (cmd_r == CH_QUERY) begin
        is_status = 1'b1;
      end
    end

    // levels and status flags come from the timers before the tick
    desc.strike_on = (stt != 8'd0);
    desc.green_on  = (gt != 8'd0);
    desc.beep_on   = (bt != 8'd0);
    desc.st_beep   = desc.beep_on;
    desc.st_green  = desc.green_on;
    desc.st_strike = desc.strike_on;

    beep_nxt   = bt;
    green_nxt  = gt;
    strike_nxt = stt;
    if (tick) begin
      if (bt != 8'd0 && bt != TMR_LATCHED) beep_nxt = bt - 8'd1;
      if (gt != 8'd0 && gt != TMR_LATCHED) green_nxt = gt - 8'd1;
      if (stt != 8'd0 && stt != TMR_LATCHED) strike_nxt = stt - 8'd1;
    end

    // 3-bit vertical counter debouncer, one counter per pin
    b    = (cnt_b_r ^ cnt_c_r) | cnt_a_r;
    c    = cnt_a_r | ~cnt_c_r;
    a    = cnt_a_r | ~(b | c);
    diff = pins ^ stable_r;
    cnt_a_nxt  = a & diff;
    cnt_b_nxt  = b & diff;
    cnt_c_nxt  = c & diff;
    done       = a & b & c & diff;
    stable_nxt = stable_r ^ done;

    // report handling; the status answer carries the debounced inputs from before this pass
    pend_nxt = is_status ? 1'b0 : pend_r;
    if (done != '0) pend_nxt = 1'b1;
    if (is_status) begin
      desc.kind = KIND_STATUS;
      desc.rpt  = stable_r;
    end else if (pend_nxt) begin
      desc.kind = KIND_REPORT;
      desc.rpt  = stable_nxt;
      pend_nxt  = 1'b0;
    end else begin
      desc.kind = KIND_NONE;
      desc.rpt  = stable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstate_r <= PS_CMD;
      cmd_r    <= 8'd0;
      parm_r   <= 8'd0;
      beep_r   <= 8'd0;
      green_r  <= 8'd0;
      strike_r <= 8'd0;
      stable_r <= '0;
      pend_r   <= 1'b1;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      cnt_c_r  <= '0;
    end else if (accept) begin
      pstate_r <= pstate_nxt;
      cmd_r    <= cmd_nxt;
      parm_r   <= parm_nxt;
      beep_r   <= beep_nxt;
      green_r  <= green_nxt;
      strike_r <= strike_nxt;
      stable_r <= stable_nxt;
      pend_r   <= pend_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      cnt_c_r  <= cnt_c_nxt;
    end
  end

endmodule

[hdl/dioc_emit.sv]
// result register and byte sequencer: turns a pass descriptor into 1, 4 or 9 transactions
// depends on dioc_pkg
`timescale 1ns / 1ps

module dioc_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  dioc_pkg::pass_desc_t desc,
  output logic                 load_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast
);
  import dioc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [3:0] idx_r, idx_nxt;
  pass_desc_t desc_r;
  logic [3:0] len;
  logic [3:0] pos;
  logic       is_last;
  logic       has_byte;
  logic [7:0] tx_byte;

  always_comb begin
    case (desc_r.kind)
      KIND_REPORT: len = LEN_REPORT;
      KIND_STATUS: len = LEN_STATUS;
      default:     len = LEN_NONE;
    endcase
  end

  assign pos      = (desc_r.kind == KIND_REPORT) ? idx_r + RPT_BASE : idx_r;
  assign is_last  = (idx_r == len - 4'd1);
  assign has_byte = (desc_r.kind != KIND_NONE);
  assign tx_byte  = has_byte ? resp_byte(pos, desc_r) : 8'h00;

  assign out_tvalid = valid_r;
  assign out_tlast  = is_last;
  assign out_tdata  = {4'd0, desc_r.beep_on, desc_r.green_on, desc_r.strike_on,
                       tx_byte, has_byte};
  assign load_ready = !valid_r || (out_tready && is_last);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (valid_r && out_tready) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
  end

endmodule

[hdl/door_io_command_controller_top.sv]
// top level of the door i/o command controller
// depends on dioc_pkg, dioc_core and dioc_emit
`timescale 1ns / 1ps

// usage
// - input stream: one transaction per main-loop pass, carrying an optional received
//   serial byte, the 16 Hz tick flag and the five raw input pins
// - output stream: every pass gives 1, 4 or 9 transactions; the final one has tlast.
//   a pass with nothing to send gives one transaction with byte_valid low
// - strike, green and beep levels repeat on every transaction of a pass
// - latency: the first transaction of a pass is valid the cycle after acceptance
// - throughput: one pass per cycle while passes send at most one transaction and
//   out_tready stays high; a pass holds the output until its last transaction is
//   taken, and the next pass is accepted in the cycle that transaction is taken
// - the pass state (parser, timers, debouncer) is updated at acceptance, so a
//   stalled output never stops the internal state from being consistent
// - output stall: the result register holds its transaction until out_tready;
//   in_tready drops until the last transaction of the held pass goes out
// - reset (rst_n low, synchronous): parser waits for a command byte, timers and
//   debouncer are cleared, and an input report is pending, so the first pass
//   that sends nothing else sends an input report
module door_io_command_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] rx_valid, [8:1] rx_byte, [9] tick, [14:10] pins
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] byte_valid, [8:1] tx_byte, [9] strike_on,
                                  // [10] green_on, [11] beep_on
  output logic        out_tlast
);
  import dioc_pkg::*;

  logic       in_fire;
  pass_desc_t desc;

  assign in_fire = in_tvalid && in_tready;

  // pass state and per-pass decision
  dioc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_fire),
    .rx_valid (in_tdata[0]),
    .rx_byte  (in_tdata[8:1]),
    .tick     (in_tdata[9]),
    .pins     (in_tdata[14:10]),
    .desc     (desc)
  );

  // output register and byte sequencer
  dioc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .desc       (desc),
    .load_ready (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // an accepted pass always shows a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted pass produced no result");

  // a transaction without a byte is the only one of its pass
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tlast)
    else $error("empty transaction not marked last");

  // no new pass is taken while a multi-byte answer is unfinished
  a_no_accept_mid_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input ready in the middle of a pass");

  // a byte-less transaction carries a zero byte
  a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == 8'h00))
    else $error("byte field not zero without byte_valid");

endmodule
